// File: design/rmf_pkg.sv
// shared types, constants and helper functions of the rgb 3x3 minimum filter
package rmf_pkg;

  localparam int unsigned MaxWidth = 2048;
  localparam int unsigned AddrW    = $clog2(MaxWidth);
  localparam int unsigned FwW      = 12;
  localparam int unsigned FhW      = 16;
  localparam int unsigned ColW     = 11;
  localparam int unsigned RowW     = 16;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned PixW     = 3 * ChanW;
  localparam int unsigned LineW    = 2 * PixW;
  localparam int unsigned WEffW    = (FwW > AddrW + 1) ? FwW : AddrW + 1;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned NumSlots = 4;
  localparam int unsigned SlotW    = $clog2(NumSlots);

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 1'b1;

  localparam logic [FwW-1:0] FrameWidthRst  = 12'd640;
  localparam logic [FhW-1:0] FrameHeightRst = 16'd480;

  localparam logic [PixW-1:0] White = {PixW{1'b1}};

  typedef logic [PixW-1:0] pix_t;

  typedef struct packed {
    pix_t             pix;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
  } res_t;

  typedef struct packed {
    logic [NumSlots-1:0] mask;
    res_t [NumSlots-1:0] slot;
  } bundle_t;

  typedef struct packed {
    pix_t             pix;
    logic [AddrW-1:0] col;
    logic [RowW-1:0]  row;
    logic             r_ge1;
    logic             r_ge2;
    logic             c_ge1;
    logic             c_ge2;
    logic             last_col;
    logic             last_row;
  } stage_t;

  function automatic pix_t pmin(input pix_t a, input pix_t b);
    pix_t res;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      res[i*ChanW +: ChanW] = (a[i*ChanW +: ChanW] < b[i*ChanW +: ChanW]) ?
                              a[i*ChanW +: ChanW] : b[i*ChanW +: ChanW];
    end
    return res;
  endfunction

endpackage

// File: design/rmf_line_mem.sv
// two-row line memory, one synchronous read port and one write port
module rmf_line_mem (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [rmf_pkg::AddrW-1:0]   rd_addr_i,
  output logic [rmf_pkg::LineW-1:0]   rd_data_o,
  input  logic                        wr_en_i,
  input  logic [rmf_pkg::AddrW-1:0]   wr_addr_i,
  input  logic [rmf_pkg::LineW-1:0]   wr_data_i
);

  logic [rmf_pkg::LineW-1:0] mem [rmf_pkg::MaxWidth];
  logic [rmf_pkg::LineW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/rmf_window.sv
// column minima, window registers and result generation for one pixel
module rmf_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  rmf_pkg::stage_t            stage_i,
  input  logic [rmf_pkg::LineW-1:0]  above_i,
  output rmf_pkg::bundle_t           bundle_o,
  output logic [rmf_pkg::LineW-1:0]  wr_data_o
);

  rmf_pkg::pix_t w3_l2_q, w3_l1_q, w2_l2_q, w2_l1_q;
  rmf_pkg::pix_t line_a, line_b, above1, above2, vm3, vm2;
  rmf_pkg::pix_t l2_3, l1_3, l2_2, l1_2;
  logic [rmf_pkg::ColW-1:0] col_cur, col_prev;
  logic [rmf_pkg::RowW-1:0] row_prev;

  assign line_a = above_i[rmf_pkg::PixW-1:0];
  assign line_b = above_i[rmf_pkg::LineW-1:rmf_pkg::PixW];

  assign above1 = stage_i.r_ge1 ? line_a : rmf_pkg::White;
  assign above2 = stage_i.r_ge2 ? line_b : rmf_pkg::White;
  assign vm3    = rmf_pkg::pmin(rmf_pkg::pmin(above2, above1), stage_i.pix);
  assign vm2    = rmf_pkg::pmin(above1, stage_i.pix);

  assign l2_3 = stage_i.c_ge2 ? w3_l2_q : rmf_pkg::White;
  assign l1_3 = stage_i.c_ge1 ? w3_l1_q : rmf_pkg::White;
  assign l2_2 = stage_i.c_ge2 ? w2_l2_q : rmf_pkg::White;
  assign l1_2 = stage_i.c_ge1 ? w2_l1_q : rmf_pkg::White;

  assign col_cur  = rmf_pkg::ColW'(stage_i.col);
  assign col_prev = rmf_pkg::ColW'(stage_i.col - rmf_pkg::AddrW'(1));
  assign row_prev = stage_i.row - rmf_pkg::RowW'(1);

  always_comb begin
    bundle_o.mask[0] = stage_i.r_ge1 & stage_i.c_ge1;
    bundle_o.mask[1] = stage_i.r_ge1 & stage_i.last_col;
    bundle_o.mask[2] = stage_i.last_row & stage_i.c_ge1;
    bundle_o.mask[3] = stage_i.last_row & stage_i.last_col;

    bundle_o.slot[0].pix = rmf_pkg::pmin(rmf_pkg::pmin(l2_3, l1_3), vm3);
    bundle_o.slot[0].col = col_prev;
    bundle_o.slot[0].row = row_prev;

    bundle_o.slot[1].pix = rmf_pkg::pmin(l1_3, vm3);
    bundle_o.slot[1].col = col_cur;
    bundle_o.slot[1].row = row_prev;

    bundle_o.slot[2].pix = rmf_pkg::pmin(rmf_pkg::pmin(l2_2, l1_2), vm2);
    bundle_o.slot[2].col = col_prev;
    bundle_o.slot[2].row = stage_i.row;

    bundle_o.slot[3].pix = rmf_pkg::pmin(l1_2, vm2);
    bundle_o.slot[3].col = col_cur;
    bundle_o.slot[3].row = stage_i.row;
  end

  // older row moves down, new pixel becomes the previous row
  assign wr_data_o = {line_a, stage_i.pix};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w3_l2_q <= '0;
      w3_l1_q <= '0;
      w2_l2_q <= '0;
      w2_l1_q <= '0;
    end else if (adv_i) begin
      w3_l2_q <= w3_l1_q;
      w3_l1_q <= vm3;
      w2_l2_q <= w2_l1_q;
      w2_l1_q <= vm2;
    end
  end

endmodule

// File: design/rmf_out_buf.sv
// result buffer that hands out up to four results of one pixel, one per transfer
module rmf_out_buf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  rmf_pkg::bundle_t              bundle_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rmf_pkg::ChanW-1:0]     out_red_o,
  output logic [rmf_pkg::ChanW-1:0]     out_green_o,
  output logic [rmf_pkg::ChanW-1:0]     out_blue_o,
  output logic [rmf_pkg::ColW-1:0]      out_col_o,
  output logic [rmf_pkg::RowW-1:0]      out_row_o,
  output logic                          last_of_run_o
);

  logic [rmf_pkg::NumSlots-1:0] mask_q, mask_d, sel_oh, rest;
  rmf_pkg::res_t [rmf_pkg::NumSlots-1:0] slot_q;
  logic [rmf_pkg::SlotW-1:0] sel;
  rmf_pkg::res_t cur;
  logic xfer;

  always_comb begin
    sel = '0;
    for (int i = rmf_pkg::NumSlots - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = rmf_pkg::SlotW'(i);
      end
    end
  end

  assign sel_oh = rmf_pkg::NumSlots'(1) << sel;
  assign rest   = mask_q & ~sel_oh;
  assign cur    = slot_q[sel];
  assign xfer   = out_valid_o & out_ready_i;

  assign out_valid_o   = |mask_q;
  assign last_of_run_o = (rest == '0);
  assign out_red_o     = cur.pix[3*rmf_pkg::ChanW-1:2*rmf_pkg::ChanW];
  assign out_green_o   = cur.pix[2*rmf_pkg::ChanW-1:rmf_pkg::ChanW];
  assign out_blue_o    = cur.pix[rmf_pkg::ChanW-1:0];
  assign out_col_o     = cur.col;
  assign out_row_o     = cur.row;

  assign free_o = (mask_q == '0) | (out_ready_i & (rest == '0));

  always_comb begin
    mask_d = mask_q;
    if (xfer) begin
      mask_d = rest;
    end
    if (load_i) begin
      mask_d = bundle_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= bundle_i.slot;
    end
  end

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> out_valid_o)
    else $error("loaded results not offered");

  a_run_goes_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && !last_of_run_o |=> out_valid_o && !free_o || out_valid_o)
    else $error("run ended without last mark");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("results overwritten before transfer");

endmodule

// File: design/rgb_min_filter_3x3.sv
// top level of the streaming rgb 3x3 minimum filter
// Streaming 3x3 minimum filter (grayscale erosion per channel) on RGB pixels
// given in raster order; neighbors outside the frame are skipped. A pixel is
// taken every clock cycle unless the output stalls: its column entry of a
// 2048 x 48-bit line memory (previous two rows) is read at the transfer and
// written back as the pixel leaves the stage register, with forwarding when
// the frame is one pixel wide. Results leave at one per clock while the
// receiver is ready, through a four-entry result buffer; a pixel in the last
// column (two results) or the last row (up to four) holds the input while
// the buffer hands them out. Writing frame_width or frame_height restarts
// the frame at row 0, column 0. The line memory needs no clearing after reset.
module rgb_min_filter_3x3 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rmf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rmf_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rmf_pkg::ChanW-1:0]     in_red_i,
  input  logic [rmf_pkg::ChanW-1:0]     in_green_i,
  input  logic [rmf_pkg::ChanW-1:0]     in_blue_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rmf_pkg::ChanW-1:0]     out_red_o,
  output logic [rmf_pkg::ChanW-1:0]     out_green_o,
  output logic [rmf_pkg::ChanW-1:0]     out_blue_o,
  output logic [rmf_pkg::ColW-1:0]      out_col_o,
  output logic [rmf_pkg::RowW-1:0]      out_row_o,
  output logic                          last_of_run_o
);

  logic [rmf_pkg::FwW-1:0]   fw_q;
  logic [rmf_pkg::FhW-1:0]   fh_q;
  logic [rmf_pkg::AddrW-1:0] col_q, col_d, c_cur;
  logic [rmf_pkg::RowW-1:0]  row_q, row_d, r_cur;
  logic [rmf_pkg::WEffW-1:0] w_ext, w_eff;
  logic [rmf_pkg::FhW-1:0]   h_eff;
  logic                      last_col, last_row, accept;

  rmf_pkg::stage_t           s1_q, s1_d;
  logic                      s1_valid_q, s1_adv;
  logic                      fwd_q;
  logic [rmf_pkg::LineW-1:0] fwd_data_q, mem_rd_data, above, wr_data;

  rmf_pkg::bundle_t          bundle;
  logic                      buf_free, buf_load;

  // effective frame size
  assign w_ext = rmf_pkg::WEffW'(fw_q);
  always_comb begin
    w_eff = w_ext;
    if (w_ext == '0) begin
      w_eff = rmf_pkg::WEffW'(1);
    end else if (w_ext > rmf_pkg::WEffW'(rmf_pkg::MaxWidth)) begin
      w_eff = rmf_pkg::WEffW'(rmf_pkg::MaxWidth);
    end
  end
  assign h_eff = (fh_q == '0) ? rmf_pkg::FhW'(1) : fh_q;

  assign c_cur = (rmf_pkg::WEffW'(col_q) >= w_eff) ? '0 : col_q;
  assign r_cur = (row_q >= h_eff) ? '0 : row_q;

  assign last_col = (rmf_pkg::WEffW'(c_cur) == w_eff - rmf_pkg::WEffW'(1));
  assign last_row = (r_cur == h_eff - rmf_pkg::FhW'(1));

  assign in_ready_o = !s1_valid_q | s1_adv;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    col_d = c_cur + rmf_pkg::AddrW'(1);
    row_d = r_cur;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : r_cur + rmf_pkg::RowW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= rmf_pkg::FrameWidthRst;
      fh_q  <= rmf_pkg::FrameHeightRst;
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rmf_pkg::CfgFrameWidth:  fw_q <= cfg_wdata_i[rmf_pkg::FwW-1:0];
        rmf_pkg::CfgFrameHeight: fh_q <= cfg_wdata_i[rmf_pkg::FhW-1:0];
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    s1_d.pix      = {in_red_i, in_green_i, in_blue_i};
    s1_d.col      = c_cur;
    s1_d.row      = r_cur;
    s1_d.r_ge1    = (r_cur != '0);
    s1_d.r_ge2    = (r_cur > rmf_pkg::RowW'(1));
    s1_d.c_ge1    = (c_cur != '0);
    s1_d.c_ge2    = (c_cur > rmf_pkg::AddrW'(1));
    s1_d.last_col = last_col;
    s1_d.last_row = last_row;
  end

  assign s1_adv   = s1_valid_q & (buf_free | (bundle.mask == '0));
  assign buf_load = s1_adv & (bundle.mask != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      fwd_q      <= s1_adv & (s1_q.col == c_cur);
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q       <= s1_d;
      fwd_data_q <= wr_data;
    end
  end

  // same column written back while read: take the write data
  assign above = fwd_q ? fwd_data_q : mem_rd_data;

  rmf_line_mem u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (c_cur),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_q.col),
    .wr_data_i (wr_data)
  );

  rmf_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (s1_adv),
    .stage_i   (s1_q),
    .above_i   (above),
    .bundle_o  (bundle),
    .wr_data_o (wr_data)
  );

  rmf_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (buf_load),
    .bundle_i      (bundle),
    .free_o        (buf_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .out_col_o     (out_col_o),
    .out_row_o     (out_row_o),
    .last_of_run_o (last_of_run_o)
  );

  a_fwd_has_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q)
    else $error("forwarding flag without pending pixel");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_q))
    else $error("stalled pixel lost or changed");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_load |-> buf_free)
    else $error("result buffer loaded while busy");

endmodule

// File: verif/rgb_min_filter_3x3_test.sv
// testbench of the rgb 3x3 minimum filter: directed and random frames against a built-in predictor
`timescale 1ns / 1ps

module rgb_min_filter_3x3_test;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned TailCycles = 16;

  typedef struct packed {
    logic [rmf_pkg::ChanW-1:0] red;
    logic [rmf_pkg::ChanW-1:0] green;
    logic [rmf_pkg::ChanW-1:0] blue;
    logic [rmf_pkg::ColW-1:0]  col;
    logic [rmf_pkg::RowW-1:0]  row;
    logic                      last;
  } min_px_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [rmf_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [rmf_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [rmf_pkg::ChanW-1:0]    in_red_i = '0;
  logic [rmf_pkg::ChanW-1:0]    in_green_i = '0;
  logic [rmf_pkg::ChanW-1:0]    in_blue_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [rmf_pkg::ChanW-1:0]    out_red_o;
  logic [rmf_pkg::ChanW-1:0]    out_green_o;
  logic [rmf_pkg::ChanW-1:0]    out_blue_o;
  logic [rmf_pkg::ColW-1:0]     out_col_o;
  logic [rmf_pkg::RowW-1:0]     out_row_o;
  logic                         last_of_run_o;

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned hold_req_cycles = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  min_px_t pending_min_q[$];

  // filter state mirror
  rmf_pkg::pix_t           row_above [rmf_pkg::MaxWidth];
  rmf_pkg::pix_t           row_above2 [rmf_pkg::MaxWidth];
  rmf_pkg::pix_t           top_d1 = '0;
  rmf_pkg::pix_t           top_d2 = '0;
  rmf_pkg::pix_t           bot_d1 = '0;
  rmf_pkg::pix_t           bot_d2 = '0;
  int unsigned             pos_col = 0;
  int unsigned             pos_row = 0;
  logic [rmf_pkg::FwW-1:0] frame_w = rmf_pkg::FrameWidthRst;
  logic [rmf_pkg::FhW-1:0] frame_h = rmf_pkg::FrameHeightRst;

  rgb_min_filter_3x3 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_red_i      (in_red_i),
    .in_green_i    (in_green_i),
    .in_blue_i     (in_blue_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_red_o     (out_red_o),
    .out_green_o   (out_green_o),
    .out_blue_o    (out_blue_o),
    .out_col_o     (out_col_o),
    .out_row_o     (out_row_o),
    .last_of_run_o (last_of_run_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("rgb_min_filter_3x3 test failed");
    $finish;
  end

  function automatic rmf_pkg::pix_t darker(input rmf_pkg::pix_t a, input rmf_pkg::pix_t b);
    rmf_pkg::pix_t m;
    m = b;
    for (int k = 0; k < 3; k++) begin
      if (a[k*rmf_pkg::ChanW +: rmf_pkg::ChanW] < b[k*rmf_pkg::ChanW +: rmf_pkg::ChanW]) begin
        m[k*rmf_pkg::ChanW +: rmf_pkg::ChanW] = a[k*rmf_pkg::ChanW +: rmf_pkg::ChanW];
      end
    end
    return m;
  endfunction

  function automatic min_px_t make_min_px(input rmf_pkg::pix_t p, input int unsigned c,
                                          input int unsigned r);
    min_px_t e;
    e.red   = p[2*rmf_pkg::ChanW +: rmf_pkg::ChanW];
    e.green = p[rmf_pkg::ChanW +: rmf_pkg::ChanW];
    e.blue  = p[0 +: rmf_pkg::ChanW];
    e.col   = rmf_pkg::ColW'(c);
    e.row   = rmf_pkg::RowW'(r);
    e.last  = 1'b0;
    return e;
  endfunction

  // expected minima caused by one accepted pixel
  function automatic void predict_minima(input rmf_pkg::pix_t px);
    int unsigned w, h, c, r, n;
    rmf_pkg::pix_t up1, up2, col_top, col_bot, t1, t2, b1, b2;
    min_px_t fresh [4];
    w = (frame_w == 0) ? 1 :
        ((frame_w > rmf_pkg::MaxWidth) ? rmf_pkg::MaxWidth : frame_w);
    h = (frame_h == 0) ? 1 : frame_h;
    if (pos_col >= w) pos_col = 0;
    if (pos_row >= h) pos_row = 0;
    c = pos_col;
    r = pos_row;
    n = 0;
    up1 = (r >= 1) ? row_above[c] : rmf_pkg::White;
    up2 = (r >= 2) ? row_above2[c] : rmf_pkg::White;
    col_top = darker(darker(up2, up1), px);
    col_bot = darker(up1, px);
    t2 = (c >= 2) ? top_d2 : rmf_pkg::White;
    t1 = (c >= 1) ? top_d1 : rmf_pkg::White;
    b2 = (c >= 2) ? bot_d2 : rmf_pkg::White;
    b1 = (c >= 1) ? bot_d1 : rmf_pkg::White;
    if (r >= 1) begin
      if (c >= 1) begin
        fresh[n] = make_min_px(darker(darker(t2, t1), col_top), c - 1, r - 1);
        n++;
      end
      if (c == w - 1) begin
        fresh[n] = make_min_px(darker(t1, col_top), c, r - 1);
        n++;
      end
    end
    if (r == h - 1) begin
      if (c >= 1) begin
        fresh[n] = make_min_px(darker(darker(b2, b1), col_bot), c - 1, r);
        n++;
      end
      if (c == w - 1) begin
        fresh[n] = make_min_px(darker(b1, col_bot), c, r);
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      fresh[i].last = (i == n - 1);
      pending_min_q = {pending_min_q, fresh[i]};
    end
    top_d2 = top_d1;
    top_d1 = col_top;
    bot_d2 = bot_d1;
    bot_d1 = col_bot;
    row_above2[c] = row_above[c];
    row_above[c] = px;
    if (c + 1 >= w) begin
      pos_col = 0;
      pos_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : check_minima
    min_px_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_min_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual col %0d row %0d",
                 $time, out_col_o, out_row_o);
        err_cnt++;
      end else begin
        want = pending_min_q.pop_front();
        check_field("red", 32'(want.red), 32'(out_red_o));
        check_field("green", 32'(want.green), 32'(out_green_o));
        check_field("blue", 32'(want.blue), 32'(out_blue_o));
        check_field("col", 32'(want.col), 32'(out_col_o));
        check_field("row", 32'(want.row), 32'(out_row_o));
        check_field("last_of_run", 32'(want.last), 32'(last_of_run_o));
      end
    end
  end

  // receiver: random idling plus long hold-offs on request
  initial begin : drive_out_ready
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_req_cycles != 0) begin
        hold_left = hold_req_cycles;
        hold_req_cycles = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  function automatic rmf_pkg::pix_t rand_pixel();
    rmf_pkg::pix_t p;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 5))
        0: p[k*rmf_pkg::ChanW +: rmf_pkg::ChanW] = '0;
        1: p[k*rmf_pkg::ChanW +: rmf_pkg::ChanW] = '1;
        default: p[k*rmf_pkg::ChanW +: rmf_pkg::ChanW] =
                   rmf_pkg::ChanW'($urandom_range(0, 255));
      endcase
    end
    return p;
  endfunction

  task automatic send_pixel(input rmf_pkg::pix_t px);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_red_i   <= px[2*rmf_pkg::ChanW +: rmf_pkg::ChanW];
    in_green_i <= px[rmf_pkg::ChanW +: rmf_pkg::ChanW];
    in_blue_i  <= px[0 +: rmf_pkg::ChanW];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_minima(px);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_min_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rmf_pkg::CfgIdxW-1:0] idx,
                           input logic [rmf_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == rmf_pkg::CfgFrameWidth) begin
      frame_w = data[rmf_pkg::FwW-1:0];
    end else begin
      frame_h = data[rmf_pkg::FhW-1:0];
    end
    pos_col = 0;
    pos_row = 0;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frame(input logic [rmf_pkg::CfgDataW-1:0] wd,
                           input logic [rmf_pkg::CfgDataW-1:0] hd);
    wait_idle();
    write_reg(rmf_pkg::CfgFrameWidth, wd);
    write_reg(rmf_pkg::CfgFrameHeight, hd);
  endtask

  // reset size 640x480, first row only: no result may come
  task automatic test_after_reset();
    repeat (5) send_pixel(rand_pixel());
  endtask

  task automatic test_small_frames();
    // zero width and zero height act as a 1x1 frame
    set_frame(16'd0, 16'd0);
    send_pixel('0);
    send_pixel(rmf_pkg::White);
    send_pixel(24'hFF00FF);
    send_pixel(24'h00FF00);
    // one column, two frames
    set_frame(16'd1, 16'd3);
    repeat (6) send_pixel(rand_pixel());
    // upper bits of the width write are dropped
    set_frame(16'hF002, 16'd2);
    send_pixel(rmf_pkg::White);
    send_pixel('0);
    send_pixel(24'h0F0F0F);
    send_pixel(24'hF0F0F0);
    set_frame(16'd3, 16'd3);
    for (int i = 0; i < 9; i++) begin
      send_pixel((i % 2 == 0) ? 24'hFF00FF : 24'h00FF00);
    end
  endtask

  task automatic test_restart_on_write();
    set_frame(16'd4, 16'd4);
    repeat (6) send_pixel(rand_pixel());
    wait_idle();
    write_reg(rmf_pkg::CfgFrameHeight, 16'd4);
    repeat (6) send_pixel(rand_pixel());
    wait_idle();
    write_reg(rmf_pkg::CfgFrameWidth, 16'd4);
    repeat (20) send_pixel(rand_pixel());
  endtask

  task automatic test_wide_frame();
    // width beyond the line store saturates
    set_frame(16'h0FFF, 16'd1);
    repeat (12) send_pixel(rand_pixel());
    set_frame(16'd2048, 16'd1);
    repeat (12) send_pixel(rand_pixel());
  endtask

  task automatic test_tall_frame();
    set_frame(16'd2, 16'hFFFF);
    repeat (10) send_pixel(rand_pixel());
    set_frame(16'd1, 16'hFFFF);
    repeat (6) send_pixel(rand_pixel());
  endtask

  task automatic test_random_frames(input int unsigned src_pct, input int unsigned snk_pct,
                                    input int unsigned n_items);
    int unsigned sent, w, h, weff, heff, n;
    logic [rmf_pkg::CfgDataW-1:0] wdata;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 19))
        0: w = 0;
        1, 2, 3, 4: w = $urandom_range(9, 40);
        default: w = $urandom_range(1, 8);
      endcase
      h = $urandom_range(0, 8);
      weff = (w == 0) ? 1 : w;
      heff = (h == 0) ? 1 : h;
      wdata = {4'($urandom_range(0, 15)), 12'(w)};
      set_frame(wdata, 16'(h));
      n = $urandom_range(1, 2 * weff * heff + 2);
      if (n > 24) n = 24;
      repeat (n) send_pixel(rand_pixel());
      sent += n;
    end
  endtask

  task automatic test_output_stall();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_frame(16'd5, 16'd5);
    hold_req_cycles = 300;
    repeat (32) send_pixel(rand_pixel());
    wait_idle();
    repeat (20) send_pixel(rand_pixel());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    src_idle_pct = 29;
    snk_idle_pct = 62;
    test_after_reset();
    test_small_frames();
    test_restart_on_write();
    test_wide_frame();
    test_tall_frame();
    test_random_frames(29, 62, 50);
    test_random_frames(62, 29, 50);
    test_random_frames(0, 0, 50);
    test_output_stall();
    wait_idle();
    if (err_cnt == 0) begin
      $display("rgb_min_filter_3x3 test passed");
    end else begin
      $display("rgb_min_filter_3x3 test failed");
    end
    $finish;
  end

endmodule
